// ----- hdl/cdq_pkg.sv -----
// ============================================================================
// cdq_pkg
// Shared types and constants for the circular deque unit: command and status
// codes, field widths and the result record passed to the output stage.
// ============================================================================
package cdq_pkg;

    // Default capacity of the deque in entries.
    localparam int DEPTH_DEFAULT = 16;

    // Field widths.
    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // Data returned by pushes, refusals and unused commands.
    localparam logic [VALUE_W-1:0] DATA_NONE = '1;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_REAR  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_PEEK_FRONT = 3'd4,
        CMD_PEEK_REAR  = 3'd5
    } cmd_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Everything about a result except the slot contents.
    typedef struct packed {
        logic    rd_ok;     // data comes from the slot memory
        status_t status;
        logic    is_empty;
        logic    is_full;
    } result_t;

endpackage

// ----- hdl/circular_deque_unit.sv -----
// ============================================================================
// circular_deque_unit
// Fixed-capacity double-ended queue kept in a ring of memory slots, with
// push, pop and peek at both ends and one result per command.
// ============================================================================
//
//  Channel  Dir  Signals                    Content
//  -------  ---  -------------------------  ----------------------------------
//  s        in   s_tvalid s_tready s_tdata  command, push_value
//  m        out  m_tvalid m_tready m_tdata  data, status, is_empty, is_full
//
//  One command is taken per cycle while no result is held back. Pointers and
//  count update at the transfer and the slot memory is written or read in the
//  same cycle; the result is shown the next cycle, with read data from the
//  memory's output register. Each command makes at most one memory access.
//  Reset clears the pointers and count; slot contents are not cleared.
//  While a result waits on m_tready, s_tready stays low.
//
module circular_deque_unit
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [2:0] command, [34:3] push_value
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [31:0] data, [33:32] status,
                                            // [34] is_empty, [35] is_full
);

    localparam int AW = $clog2(DEPTH);

    logic               fire;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;
    result_t            result;

    logic               out_valid_reg, out_valid_next;
    result_t            out_res_reg;
    logic [VALUE_W-1:0] out_data;

    // Input transfer; the output register frees up in the same cycle it drains.
    assign s_tready = !out_valid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;

    cdq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .command    (s_tdata[CMD_W-1:0]),
        .push_value (s_tdata[CMD_W+VALUE_W-1:CMD_W]),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .result     (result)
    );

    cdq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Output stage valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result record; the memory read register holds the slot data alongside it.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_res_reg <= result;
        end
    end

    assign out_data = out_res_reg.rd_ok ? mem_rdata : DATA_NONE;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {
        (M_TDATA_W - VALUE_W - STATUS_W - 2)'(0),
        out_res_reg.is_full,
        out_res_reg.is_empty,
        out_res_reg.status,
        out_data
    };

endmodule

// ----- hdl/cdq_ram.sv -----
// ============================================================================
// cdq_ram
// Generic single-clock RAM with one write port and one read port. The read
// data is registered and only updates when a read is enabled.
// ============================================================================
module cdq_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hdl/cdq_ctrl.sv -----
// ============================================================================
// cdq_ctrl
// Pointer and occupancy control for the deque. Decodes one command per
// transfer, updates head, tail and count, and drives the slot memory access.
// ============================================================================
module cdq_ctrl
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     fire,
    input  logic [CMD_W-1:0]         command,
    input  logic [VALUE_W-1:0]       push_value,
    output logic                     mem_we,
    output logic [$clog2(DEPTH)-1:0] mem_waddr,
    output logic [VALUE_W-1:0]       mem_wdata,
    output logic                     mem_re,
    output logic [$clog2(DEPTH)-1:0] mem_raddr,
    output result_t                  result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;

    logic          empty;
    logic          full;
    logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;
    logic          wr, rd;
    logic [AW-1:0] addr;
    status_t       status;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == FULL_CNT);

    // Ring neighbors of both pointers.
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - AW'(1);
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + AW'(1);
    assign tail_dec = (tail_reg == '0) ? LAST_IDX : tail_reg - AW'(1);

    // Command decode.
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        wr         = 1'b0;
        rd         = 1'b0;
        addr       = head_reg;
        status     = ST_OK;
        unique case (cmd_t'(command))
            CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    head_next  = head_dec;
                    addr       = head_dec;
                    wr         = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_PUSH_REAR:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    tail_next  = tail_inc;
                    addr       = tail_reg;
                    wr         = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    head_next  = head_inc;
                    addr       = head_reg;
                    rd         = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            CMD_POP_REAR:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    tail_next  = tail_dec;
                    addr       = tail_dec;
                    rd         = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            CMD_PEEK_FRONT:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    addr = head_reg;
                    rd   = 1'b1;
                end
            end
            CMD_PEEK_REAR:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    addr = tail_dec;
                    rd   = 1'b1;
                end
            end
            default:
            begin
                // Unused codes leave the deque as it is.
                status = ST_OK;
            end
        endcase
    end

    // Memory access; a command either writes or reads, never both.
    assign mem_we    = fire && wr;
    assign mem_waddr = addr;
    assign mem_wdata = push_value;
    assign mem_re    = fire && rd;
    assign mem_raddr = addr;

    // Result record with the flags after the operation.
    assign result.rd_ok    = rd;
    assign result.status   = status;
    assign result.is_empty = (count_next == '0);
    assign result.is_full  = (count_next == FULL_CNT);

    // Pointer and count registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (fire)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- test/circular_deque_checker.sv -----
// ============================================================================
// circular_deque_checker
// Watches both stream channels of the circular deque unit. It keeps its own
// copy of the ring, pointers and count, works out the result of every
// accepted command and compares each returned result field by field.
// ============================================================================
module circular_deque_checker
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // [2:0] command, [34:3] push_value
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,    // [31:0] data, [33:32] status,
                                             // [34] is_empty, [35] is_full
    output int                   mismatches,
    output int                   outstanding,
    output int                   checked,
    output int                   full_refusals,
    output int                   empty_refusals
);
    timeunit 1ns;
    timeprecision 1ps;

    // One expected result, in the order of the output fields.
    typedef struct packed {
        logic [VALUE_W-1:0] data;
        status_t            status;
        logic               is_empty;
        logic               is_full;
    } deque_result_t;

    // Shadow copy of the deque.
    logic [VALUE_W-1:0] ring [DEPTH];
    int unsigned        front_idx;
    int unsigned        rear_idx;
    int unsigned        fill;

    // Results still owed by the block, oldest first.
    deque_result_t      expected_q [$];

    initial
    begin
        mismatches     = 0;
        outstanding    = 0;
        checked        = 0;
        full_refusals  = 0;
        empty_refusals = 0;
    end

    function automatic int unsigned ring_after(input int unsigned i);
        return (i == DEPTH - 1) ? 0 : i + 1;
    endfunction

    function automatic int unsigned ring_before(input int unsigned i);
        return (i == 0) ? DEPTH - 1 : i - 1;
    endfunction

    // Prints one failure line and counts it.
    task automatic report_failure(input string msg);
        $display("[%0t] FAIL: %s", $realtime, msg);
        mismatches++;
    endtask

    // Applies one command to the shadow deque and queues the result it gives.
    task automatic predict_command(input logic [CMD_W-1:0] code,
                                   input logic [VALUE_W-1:0] value);
        deque_result_t r;
        logic          was_empty;
        logic          was_full;

        r.data    = DATA_NONE;
        r.status  = ST_OK;
        was_empty = (fill == 0);
        was_full  = (fill == DEPTH);

        case (code)
            CMD_PUSH_FRONT:
            begin
                if (was_full)
                    r.status = ST_FULL;
                else
                begin
                    front_idx       = ring_before(front_idx);
                    ring[front_idx] = value;
                    fill++;
                end
            end
            CMD_PUSH_REAR:
            begin
                if (was_full)
                    r.status = ST_FULL;
                else
                begin
                    ring[rear_idx] = value;
                    rear_idx       = ring_after(rear_idx);
                    fill++;
                end
            end
            CMD_POP_FRONT:
            begin
                if (was_empty)
                    r.status = ST_EMPTY;
                else
                begin
                    r.data    = ring[front_idx];
                    front_idx = ring_after(front_idx);
                    fill--;
                end
            end
            CMD_POP_REAR:
            begin
                if (was_empty)
                    r.status = ST_EMPTY;
                else
                begin
                    rear_idx = ring_before(rear_idx);
                    r.data   = ring[rear_idx];
                    fill--;
                end
            end
            CMD_PEEK_FRONT:
            begin
                if (was_empty)
                    r.status = ST_EMPTY;
                else
                    r.data = ring[front_idx];
            end
            CMD_PEEK_REAR:
            begin
                if (was_empty)
                    r.status = ST_EMPTY;
                else
                    r.data = ring[ring_before(rear_idx)];
            end
            default:
            begin
                // Unused codes leave everything as it is.
            end
        endcase

        r.is_empty = (fill == 0);
        r.is_full  = (fill == DEPTH);
        if (r.status == ST_FULL)
            full_refusals++;
        if (r.status == ST_EMPTY)
            empty_refusals++;
        expected_q.push_back(r);
    endtask

    // Compares one returned result with the oldest expectation.
    task automatic check_result(input logic [M_TDATA_W-1:0] word);
        deque_result_t want;

        if (expected_q.size() == 0)
        begin
            report_failure($sformatf("result %h arrived with nothing expected", word));
            return;
        end
        want = expected_q.pop_front();
        checked++;
        if (word[31:0] !== want.data)
            report_failure($sformatf("data expected %h, got %h", want.data, word[31:0]));
        if (word[33:32] !== want.status)
            report_failure($sformatf("status expected %0d, got %0d",
                                     want.status, word[33:32]));
        if (word[34] !== want.is_empty)
            report_failure($sformatf("is_empty expected %b, got %b",
                                     want.is_empty, word[34]));
        if (word[35] !== want.is_full)
            report_failure($sformatf("is_full expected %b, got %b",
                                     want.is_full, word[35]));
    endtask

    // Results are matched before new commands are predicted: a result always
    // belongs to a command taken at an earlier edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_idx = 0;
            rear_idx  = 0;
            fill      = 0;
            expected_q.delete();
            outstanding = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (s_tvalid && s_tready)
                predict_command(s_tdata[2:0], s_tdata[34:3]);
            outstanding = expected_q.size();
        end
    end

endmodule

// ----- test/circular_deque_unit_tb.sv -----
// ============================================================================
// circular_deque_unit_tb
// Drives commands into the circular deque unit and gives the verdict. A short
// directed run covers both empty and full refusals, the unused codes and the
// value extremes; random bursts that lean toward filling, draining or neither
// follow, under three idling patterns and one long output stall. The checker
// module does all prediction and comparison.
// ============================================================================
module circular_deque_unit_tb import cdq_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 550;
    localparam int HOLD_CYCLES  = 80;

    // Command codes that the block treats as no operation.
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

    // Leaning of a random burst of commands.
    typedef enum int {
        LEAN_FILL,
        LEAN_DRAIN,
        LEAN_MIXED
    } lean_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;    // [2:0] command, [34:3] push_value
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // [31:0] data, [33:32] status,
                                            // [34] is_empty, [35] is_full

    int  mismatches;
    int  outstanding;
    int  checked;
    int  full_refusals;
    int  empty_refusals;

    int  send_idle_pct = 38;
    int  recv_idle_pct = 49;
    bit  pressure_req  = 1'b0;
    int  cmd_count [8];

    // Clock.
    always #5 clk = ~clk;

    circular_deque_unit #(
        .DEPTH (DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    circular_deque_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .checked        (checked),
        .full_refusals  (full_refusals),
        .empty_refusals (empty_refusals)
    );

    // Offers one command, with random idle cycles first, and waits for its
    // transfer. Valid stays high afterward so back-to-back items never dip.
    task automatic send_command(input logic [CMD_W-1:0] code,
                                input logic [VALUE_W-1:0] value);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - CMD_W - VALUE_W){1'b0}}, value, code};
        do
            @(posedge clk);
        while (!s_tready);
        cmd_count[code]++;
    endtask

    // Picks one random command for a burst with the given leaning.
    task automatic pick_command(input lean_t lean,
                                output logic [CMD_W-1:0] code,
                                output logic [VALUE_W-1:0] value);
        int roll;
        int push_pct;

        push_pct = (lean == LEAN_FILL) ? 72 : (lean == LEAN_DRAIN) ? 24 : 48;
        roll     = $urandom_range(99);
        if (roll < 4)
            code = $urandom_range(1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
        else if (roll < 4 + push_pct)
            code = $urandom_range(1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
        else
        begin
            case ($urandom_range(9))
                0, 1, 2: code = CMD_POP_FRONT;
                3, 4, 5: code = CMD_POP_REAR;
                6, 7:    code = CMD_PEEK_FRONT;
                default: code = CMD_PEEK_REAR;
            endcase
        end

        // Mostly random values, with the extremes now and then.
        case ($urandom_range(15))
            0:       value = 32'h8000_0000;
            1:       value = 32'h7FFF_FFFF;
            2:       value = 32'hFFFF_FFFF;
            3:       value = 32'h0000_0000;
            default: value = $urandom();
        endcase
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request.
    initial
    begin
        int hold_left;
        bit pressure_done;

        hold_left     = 0;
        pressure_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (pressure_req && !pressure_done)
            begin
                hold_left     = HOLD_CYCLES;
                pressure_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        logic [CMD_W-1:0]   code;
        logic [VALUE_W-1:0] value;
        lean_t              lean;
        int                 burst;
        int                 sent;
        int                 per_phase;
        int                 wait_cycles;

        foreach (cmd_count[i])
            cmd_count[i] = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Refusals on the empty deque.
        send_command(CMD_PEEK_FRONT, 32'h0);
        send_command(CMD_PEEK_REAR, 32'h0);
        send_command(CMD_POP_FRONT, 32'h0);
        send_command(CMD_POP_REAR, 32'h0);

        // Value extremes at both ends, then the unused codes.
        send_command(CMD_PUSH_FRONT, 32'h8000_0000);
        send_command(CMD_PUSH_REAR, 32'h7FFF_FFFF);
        send_command(CMD_PEEK_FRONT, 32'h0);
        send_command(CMD_PEEK_REAR, 32'h0);
        send_command(CMD_UNUSED_LO, 32'h0);
        send_command(CMD_UNUSED_HI, 32'hFFFF_FFFF);

        // Fill to capacity from both ends, so the front pointer wraps.
        for (int i = 0; i < DEPTH - 2; i++)
        begin
            value = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom();
            send_command((i % 2) ? CMD_PUSH_REAR : CMD_PUSH_FRONT, value);
        end

        // Push into the full deque, then leave it from both ends.
        send_command(CMD_PUSH_FRONT, $urandom());
        send_command(CMD_POP_REAR, 32'h0);
        send_command(CMD_POP_FRONT, 32'h0);

        // Random bursts under three idling patterns; the last phase also
        // carries the long output stall.
        per_phase = RANDOM_ITEMS / 3;
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 38;
                    recv_idle_pct = 49;
                end
                1:
                begin
                    send_idle_pct = 49;
                    recv_idle_pct = 38;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    pressure_req  = 1'b1;
                end
            endcase
            sent = 0;
            while (sent < per_phase)
            begin
                lean  = lean_t'($urandom_range(2));
                burst = $urandom_range(30, 12);
                for (int k = 0; k < burst && sent < per_phase; k++)
                begin
                    pick_command(lean, code, value);
                    send_command(code, value);
                    sent++;
                end
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;

        // Drain what is still owed before the verdict.
        wait_cycles = 0;
        while (outstanding != 0 && wait_cycles < 2000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (4) @(posedge clk);

        if (outstanding != 0)
            $display("%0d expected results never arrived", outstanding);
        $display("Sent push %0d/%0d, pop %0d/%0d, peek %0d/%0d (front/rear), unused %0d.",
                 cmd_count[CMD_PUSH_FRONT], cmd_count[CMD_PUSH_REAR],
                 cmd_count[CMD_POP_FRONT], cmd_count[CMD_POP_REAR],
                 cmd_count[CMD_PEEK_FRONT], cmd_count[CMD_PEEK_REAR],
                 cmd_count[CMD_UNUSED_LO] + cmd_count[CMD_UNUSED_HI]);
        $display("Checked %0d results: %0d refused as full, %0d refused as empty.",
                 checked, full_refusals, empty_refusals);
        if (mismatches == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2_000_000;
        $display("Run timed out");
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- circular_deque_unit.f -----
hdl/cdq_pkg.sv
hdl/cdq_ram.sv
hdl/cdq_ctrl.sv
hdl/circular_deque_unit.sv
test/circular_deque_checker.sv
test/circular_deque_unit_tb.sv
